// File: hw/rtl/ufre_pkg.sv
// Shared types, constants and the control program of the unwind frame record encoder.
package ufre_pkg;

    localparam int unsigned UFRE_MAX_RECORD_BYTES = 128;

    localparam int unsigned POS_W   = 7;
    localparam int unsigned WIDX_W  = 5;
    localparam int unsigned PC_W    = 5;
    localparam int unsigned WORDS   = 32;
    localparam int unsigned LOOP_W  = 4;

    localparam logic [WIDX_W-1:0] LEN_WORD      = 5'd5;
    localparam logic [POS_W-1:0]  LEN_BIAS      = 7'd28;
    localparam logic [31:0]       PCREL_BIAS    = 32'd28;
    localparam logic [WIDX_W-1:0] LAST_WORD_MAX = 5'd28;

    localparam logic [7:0] ADV_SHORT  = 8'h40;
    localparam logic [7:0] ADV_LOC1   = 8'h02;
    localparam logic [7:0] ADV_LOC2   = 8'h03;
    localparam logic [7:0] DEF_CFA_OF = 8'h0e;
    localparam logic [7:0] OFS_EXT    = 8'h05;
    localparam logic [7:0] OFS_LR     = 8'h9e;
    localparam logic [7:0] OFS_GPR    = 8'h93;
    localparam logic [7:0] VREG_BASE  = 8'd72;
    localparam logic [15:0] VEC_K0    = 16'h0060;

    localparam logic [LOOP_W-1:0] GPR_LAST = 4'd11;
    localparam logic [LOOP_W-1:0] VEC_LAST = 4'd7;

    localparam logic [1:0] CFG_WRITE_BASE = 2'd0;
    localparam logic [1:0] CFG_EXEC_BASE  = 2'd1;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_WORD = 3'd1,
        OP_BYTE = 3'd2,
        OP_ULEB = 3'd3,
        OP_PAD  = 3'd4
    } t_op;

    typedef enum logic [2:0] {
        SRC_IMM   = 3'd0,
        SRC_ACC   = 3'd1,
        SRC_CSIZE = 3'd2,
        SRC_ADV1  = 3'd3,
        SRC_FLO   = 3'd4,
        SRC_FHI   = 3'd5,
        SRC_GPR   = 3'd6,
        SRC_VREG  = 3'd7
    } t_src;

    typedef enum logic [1:0] {
        ACC_HOLD  = 2'd0,
        ACC_BASE  = 2'd1,
        ACC_EXEC  = 2'd2,
        ACC_PCREL = 2'd3
    } t_acc;

    typedef enum logic [2:0] {
        ULD_NONE  = 3'd0,
        ULD_SSIZE = 3'd1,
        ULD_GPR   = 3'd2,
        ULD_VEC   = 3'd3,
        ULD_LR    = 3'd4
    } t_uld;

    typedef enum logic [3:0] {
        C_NEVER   = 4'd0,
        C_ALWAYS  = 4'd1,
        C_NOFRAME = 4'd2,
        C_NOALLOC = 4'd3,
        C_FGE64   = 4'd4,
        C_FGE256  = 4'd5,
        C_THUNK   = 4'd6,
        C_NOLR    = 4'd7,
        C_LOOP12  = 4'd8,
        C_LOOP8   = 4'd9
    } t_cond;

    typedef struct packed {
        t_op             op;
        t_src            src;
        t_acc            acc;
        t_uld            uld;
        t_cond           cond;
        logic            loop;
        logic            last;
        logic [PC_W-1:0] target;
        logic [31:0]     imm;
    } t_ctl;

    typedef struct packed {
        logic run;
        logic taken;
        t_ctl ctl;
    } t_cmd;

    typedef struct packed {
        logic no_frame;
        logic no_alloc;
        logic f_ge64;
        logic f_ge256;
        logic thunk;
        logic no_lr;
        logic gpr_end;
        logic vec_end;
        logic hold;
    } t_stat;

    typedef struct packed {
        logic              en;
        logic [WIDX_W-1:0] addr;
        logic [3:0]        be;
        logic [31:0]       data;
    } t_wr;

    function automatic t_ctl ufre_rom(input logic [PC_W-1:0] pc);
        t_ctl c;
        c = '0;
        case (pc)
            5'd0: begin
                c.op = OP_WORD; c.imm = 32'h0000_0010; c.acc = ACC_BASE;
            end
            5'd1: begin
                c.op = OP_WORD; c.imm = 32'h0000_0000; c.acc = ACC_EXEC;
            end
            5'd2: begin
                c.op = OP_WORD; c.imm = 32'h0052_7a01; c.acc = ACC_PCREL;
            end
            5'd3: begin
                c.op = OP_WORD; c.imm = 32'h011e_7804;
            end
            5'd4: begin
                c.op = OP_WORD; c.imm = 32'h001f_0c1b;
            end
            5'd5: begin
                c.op = OP_WORD; c.imm = 32'h0000_0000;
            end
            5'd6: begin
                c.op = OP_WORD; c.imm = 32'h0000_0018;
            end
            5'd7: begin
                c.op = OP_WORD; c.src = SRC_ACC;
            end
            5'd8: begin
                c.op = OP_WORD; c.src = SRC_CSIZE;
            end
            5'd9: begin
                c.op = OP_BYTE; c.cond = C_NOFRAME; c.target = 5'd30;
            end
            5'd10: begin
                c.cond = C_NOALLOC; c.target = 5'd19;
            end
            5'd11: begin
                c.cond = C_FGE64; c.target = 5'd13;
            end
            5'd12: begin
                c.op = OP_BYTE; c.src = SRC_ADV1; c.cond = C_ALWAYS; c.target = 5'd19;
            end
            5'd13: begin
                c.cond = C_FGE256; c.target = 5'd16;
            end
            5'd14: begin
                c.op = OP_BYTE; c.imm = {24'h0, ADV_LOC1};
            end
            5'd15: begin
                c.op = OP_BYTE; c.src = SRC_FLO; c.cond = C_ALWAYS; c.target = 5'd19;
            end
            5'd16: begin
                c.op = OP_BYTE; c.imm = {24'h0, ADV_LOC2};
            end
            5'd17: begin
                c.op = OP_BYTE; c.src = SRC_FLO;
            end
            5'd18: begin
                c.op = OP_BYTE; c.src = SRC_FHI;
            end
            5'd19: begin
                c.op = OP_BYTE; c.imm = {24'h0, DEF_CFA_OF}; c.uld = ULD_SSIZE;
            end
            5'd20: begin
                c.op = OP_ULEB;
            end
            5'd21: begin
                c.cond = C_THUNK; c.target = 5'd25;
            end
            5'd22: begin
                c.cond = C_NOLR; c.target = 5'd30;
            end
            5'd23: begin
                c.op = OP_BYTE; c.imm = {24'h0, OFS_LR}; c.uld = ULD_LR;
            end
            5'd24: begin
                c.op = OP_ULEB; c.cond = C_ALWAYS; c.target = 5'd30;
            end
            5'd25: begin
                c.op = OP_BYTE; c.src = SRC_GPR; c.uld = ULD_GPR;
            end
            5'd26: begin
                c.op = OP_ULEB; c.cond = C_LOOP12; c.target = 5'd25; c.loop = 1'b1;
            end
            5'd27: begin
                c.op = OP_BYTE; c.imm = {24'h0, OFS_EXT};
            end
            5'd28: begin
                c.op = OP_BYTE; c.src = SRC_VREG; c.uld = ULD_VEC;
            end
            5'd29: begin
                c.op = OP_ULEB; c.cond = C_LOOP8; c.target = 5'd27; c.loop = 1'b1;
            end
            5'd30: begin
                c.op = OP_PAD;
            end
            5'd31: begin
                c.op = OP_WORD; c.imm = 32'h0000_0000; c.last = 1'b1;
            end
            default: begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

// File: hw/rtl/unwind_frame_record_encoder.sv
// Top level of the unwind frame record encoder.
//
// One request on the slave stream describes one function; the block answers
// with its exception-frame record (CIE, FDE, zero terminator) as a run of
// 32-bit little-endian words on the master stream, tlast on the terminator.
// tuser on the master side is the layout error flag, the same on every word.
// The configuration channel writes the write and execute base registers; it
// is always ready and is meant to be written only while no record is open.
// A request is taken only while the block is idle. The control program then
// writes the record into a word memory: one step per record byte, one per
// fixed word, plus one for each bare branch test and one to end the padding.
// The words then leave one per cycle while the receiver is ready, from the
// output register, 11 to 29 of them. When the receiver stalls, the output
// register holds its word and the next memory read waits. A new request is
// taken in the cycle after the terminator word is taken. Reset clears the
// base registers and returns the block to idle; the record memory needs no
// clearing.
module unwind_frame_record_encoder import ufre_pkg::*; #(
    parameter int unsigned MAX_RECORD_BYTES = UFRE_MAX_RECORD_BYTES
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // write address, code address, code length, frame size,
    // allocation offset, saved link register offset, then zero fill.
    input  logic [215:0] i_s_axis_tdata,
    // is_thunk.
    input  logic         i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // record_word, word_index, then zero fill.
    output logic [39:0]  o_m_axis_tdata,
    output logic         o_m_axis_tlast,
    // layout_error.
    output logic         o_m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data
);

    // Only the low halves of the bases reach the 32-bit start offset.
    logic [31:0] r_write_base;
    logic [31:0] r_exec_base;

    logic              accept;
    logic              in_ready;
    logic              drain;
    logic              drained;
    t_cmd              cmd;
    t_stat             stat;
    t_wr               wr;
    logic [POS_W-1:0]  pos;
    logic              flag;
    logic [31:0]       word;
    logic [WIDX_W-1:0] index;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = in_ready;
    assign accept          = i_s_axis_tvalid && in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_base <= '0;
            r_exec_base  <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WRITE_BASE: r_write_base <= i_cfg_data[31:0];
                CFG_EXEC_BASE:  r_exec_base  <= i_cfg_data[31:0];
                default: begin
                    r_write_base <= r_write_base;
                end
            endcase
        end
    end

    ufre_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_stat     (stat),
        .i_drained  (drained),
        .o_cmd      (cmd),
        .o_in_ready (in_ready),
        .o_drain    (drain)
    );

    ufre_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_waddr      (i_s_axis_tdata[31:0]),
        .i_caddr      (i_s_axis_tdata[95:64]),
        .i_csize      (i_s_axis_tdata[159:128]),
        .i_ssize      (i_s_axis_tdata[175:160]),
        .i_alloc      (i_s_axis_tdata[193:176]),
        .i_thunk      (i_s_axis_tuser),
        .i_lr         (i_s_axis_tdata[209:194]),
        .i_write_base (r_write_base),
        .i_exec_base  (r_exec_base),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .o_wr         (wr),
        .o_pos        (pos),
        .o_flag       (flag)
    );

    ufre_buf #(
        .MAX_RECORD_BYTES (MAX_RECORD_BYTES)
    ) u_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (accept),
        .i_drain   (drain),
        .i_wr      (wr),
        .i_pos     (pos),
        .i_flag    (flag),
        .i_tready  (i_m_axis_tready),
        .o_tvalid  (o_m_axis_tvalid),
        .o_word    (word),
        .o_index   (index),
        .o_last    (o_m_axis_tlast),
        .o_err     (o_m_axis_tuser),
        .o_drained (drained)
    );

    assign o_m_axis_tdata = {3'b000, index, word};

    a_one_record_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_axis_tready |-> !o_m_axis_tvalid)
        else $error("new request taken while a record word is pending");

endmodule

// File: hw/rtl/ufre_seq.sv
// Program counter, control store and phase control of the record encoder.
module ufre_seq import ufre_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_accept,
    input  t_stat i_stat,
    input  logic  i_drained,
    output t_cmd  o_cmd,
    output logic  o_in_ready,
    output logic  o_drain
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_BUILD = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state          r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_ctl            ctl;
    logic            taken;

    assign ctl = ufre_rom(r_pc);

    always_comb begin
        case (ctl.cond)
            C_NEVER:   taken = 1'b0;
            C_ALWAYS:  taken = 1'b1;
            C_NOFRAME: taken = i_stat.no_frame;
            C_NOALLOC: taken = i_stat.no_alloc;
            C_FGE64:   taken = i_stat.f_ge64;
            C_FGE256:  taken = i_stat.f_ge256;
            C_THUNK:   taken = i_stat.thunk;
            C_NOLR:    taken = i_stat.no_lr;
            C_LOOP12:  taken = !i_stat.gpr_end;
            C_LOOP8:   taken = !i_stat.vec_end;
            default:   taken = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        case (r_state)
            ST_IDLE: begin
                if (i_accept) begin
                    n_state = ST_BUILD;
                    n_pc    = '0;
                end
            end
            ST_BUILD: begin
                if (!i_stat.hold) begin
                    if (ctl.last) begin
                        n_state = ST_DRAIN;
                    end else if (taken) begin
                        n_pc = ctl.target;
                    end else begin
                        n_pc = r_pc + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (i_drained) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

    assign o_cmd.run   = (r_state == ST_BUILD);
    assign o_cmd.taken = taken;
    assign o_cmd.ctl   = ctl;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_drain     = (r_state == ST_DRAIN);

endmodule

// File: hw/rtl/ufre_dp.sv
// Datapath driven by the control words: operands, address arithmetic, LEB128 and byte writes.
module ufre_dp import ufre_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [31:0]      i_waddr,
    input  logic [31:0]      i_caddr,
    input  logic [31:0]      i_csize,
    input  logic [15:0]      i_ssize,
    input  logic [17:0]      i_alloc,
    input  logic             i_thunk,
    input  logic [15:0]      i_lr,
    input  logic [31:0]      i_write_base,
    input  logic [31:0]      i_exec_base,
    input  t_cmd             i_cmd,
    output t_stat            o_stat,
    output t_wr              o_wr,
    output logic [POS_W-1:0] o_pos,
    output logic             o_flag
);

    logic [31:0]       r_waddr, r_caddr, r_csize, r_acc;
    logic [15:0]       r_ssize, r_lr, r_uleb;
    logic [17:0]       r_alloc;
    logic              r_thunk;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [LOOP_W-1:0] r_i;
    logic              r_flag;

    logic [15:0] f;
    logic        more;
    logic        pad_more;
    logic        hold;
    logic        done;
    logic [15:0] k;
    logic        under;
    logic [15:0] diff;
    logic [7:0]  byte_val;
    logic [31:0] word_val;

    assign f        = r_alloc[17:2];
    assign more     = |r_uleb[15:7];
    assign pad_more = |r_pos[2:0];
    assign hold     = (i_cmd.ctl.op == OP_ULEB && more) || (i_cmd.ctl.op == OP_PAD && pad_more);
    assign done     = i_cmd.run && !hold;

    always_comb begin
        case (i_cmd.ctl.uld)
            ULD_GPR: k = {9'b0, r_i, 3'b0};
            ULD_VEC: k = VEC_K0 + {8'b0, r_i, 4'b0};
            ULD_LR:  k = r_lr;
            default: k = '0;
        endcase
    end

    assign under = (k > r_ssize);
    assign diff  = r_ssize - k;

    always_comb begin
        case (i_cmd.ctl.src)
            SRC_ADV1: byte_val = ADV_SHORT | {2'b00, f[5:0]};
            SRC_FLO:  byte_val = f[7:0];
            SRC_FHI:  byte_val = f[15:8];
            SRC_GPR:  byte_val = OFS_GPR + {4'b0, r_i};
            SRC_VREG: byte_val = VREG_BASE + {4'b0, r_i};
            default:  byte_val = i_cmd.ctl.imm[7:0];
        endcase
        case (i_cmd.ctl.src)
            SRC_ACC:   word_val = r_acc;
            SRC_CSIZE: word_val = r_csize;
            default:   word_val = i_cmd.ctl.imm;
        endcase
    end

    always_comb begin
        o_wr.en   = 1'b0;
        o_wr.addr = r_pos[POS_W-1:2];
        o_wr.be   = 4'b0001 << r_pos[1:0];
        o_wr.data = {4{byte_val}};
        n_pos     = r_pos;
        case (i_cmd.ctl.op)
            OP_WORD: begin
                o_wr.en   = i_cmd.run;
                o_wr.be   = 4'hf;
                o_wr.data = word_val;
                n_pos     = r_pos + 7'd4;
            end
            OP_BYTE: begin
                o_wr.en = i_cmd.run;
                n_pos   = r_pos + 7'd1;
            end
            OP_ULEB: begin
                o_wr.en   = i_cmd.run;
                o_wr.data = {4{more, r_uleb[6:0]}};
                n_pos     = r_pos + 7'd1;
            end
            OP_PAD: begin
                o_wr.en   = i_cmd.run && pad_more;
                o_wr.data = '0;
                if (pad_more) begin
                    n_pos = r_pos + 7'd1;
                end
            end
            default: begin
                o_wr.en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_waddr <= i_waddr;
            r_caddr <= i_caddr;
            r_csize <= i_csize;
            r_ssize <= i_ssize;
            r_alloc <= i_alloc;
            r_thunk <= i_thunk;
            r_lr    <= i_lr;
        end
        if (i_cmd.run && i_cmd.ctl.op == OP_ULEB) begin
            r_uleb <= r_uleb >> 7;
        end else if (done) begin
            case (i_cmd.ctl.uld)
                ULD_SSIZE: r_uleb <= r_ssize;
                ULD_GPR, ULD_VEC, ULD_LR: r_uleb <= under ? 16'd0 : {3'b000, diff[15:3]};
                default: r_uleb <= r_uleb;
            endcase
        end
        if (done) begin
            case (i_cmd.ctl.acc)
                ACC_BASE:  r_acc <= r_waddr - i_write_base;
                ACC_EXEC:  r_acc <= r_acc + i_exec_base + PCREL_BIAS;
                ACC_PCREL: r_acc <= r_caddr - r_acc;
                default:   r_acc <= r_acc;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_i    <= '0;
            r_flag <= 1'b0;
        end else if (i_accept) begin
            r_pos  <= '0;
            r_i    <= '0;
            r_flag <= 1'b0;
        end else if (i_cmd.run) begin
            r_pos <= n_pos;
            if (done && i_cmd.ctl.loop) begin
                r_i <= i_cmd.taken ? r_i + 1'b1 : '0;
            end
            if (done && under && i_cmd.ctl.uld != ULD_NONE && i_cmd.ctl.uld != ULD_SSIZE) begin
                r_flag <= 1'b1;
            end
        end
    end

    assign o_stat.no_frame = (r_ssize == 16'd0);
    assign o_stat.no_alloc = (r_alloc == 18'd0);
    assign o_stat.f_ge64   = |f[15:6];
    assign o_stat.f_ge256  = |f[15:8];
    assign o_stat.thunk    = r_thunk;
    assign o_stat.no_lr    = (r_lr == 16'd0);
    assign o_stat.gpr_end  = (r_i == GPR_LAST);
    assign o_stat.vec_end  = (r_i == VEC_LAST);
    assign o_stat.hold     = hold;

    assign o_pos  = r_pos;
    assign o_flag = r_flag;

    a_wr_in_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr.en |-> o_wr.addr <= LAST_WORD_MAX)
        else $error("record write beyond the longest possible record");

    a_loop_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_i <= GPR_LAST)
        else $error("save-rule loop counter out of range");

endmodule

// File: hw/rtl/ufre_buf.sv
// Record word memory and the output register that streams the finished record.
module ufre_buf import ufre_pkg::*; #(
    parameter int unsigned MAX_RECORD_BYTES = UFRE_MAX_RECORD_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_drain,
    input  t_wr               i_wr,
    input  logic [POS_W-1:0]  i_pos,
    input  logic              i_flag,
    input  logic              i_tready,
    output logic              o_tvalid,
    output logic [31:0]       o_word,
    output logic [WIDX_W-1:0] o_index,
    output logic              o_last,
    output logic              o_err,
    output logic              o_drained
);

    localparam logic [8:0] MaxBytes = 9'(MAX_RECORD_BYTES);

    logic [31:0]       r_mem [WORDS];
    logic [WIDX_W-1:0] r_idx;
    logic              r_done;
    logic              r_valid;
    logic [31:0]       r_word;
    logic [WIDX_W-1:0] r_index;
    logic              r_last;
    logic              r_err;

    logic [WIDX_W-1:0] last_idx;
    logic [POS_W-1:0]  body_len;
    logic              load;
    logic              too_long;

    assign last_idx = i_pos[POS_W-1:2] - 5'd1;
    assign body_len = i_pos - LEN_BIAS;
    assign too_long = ({2'b00, i_pos} > MaxBytes);
    assign load     = i_drain && !r_done && (!r_valid || i_tready);

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            for (int b = 0; b < 4; b++) begin
                if (i_wr.be[b]) begin
                    r_mem[i_wr.addr][b*8 +: 8] <= i_wr.data[b*8 +: 8];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word  <= (r_idx == LEN_WORD) ? {25'b0, body_len} : r_mem[r_idx];
            r_index <= r_idx;
            r_last  <= (r_idx == last_idx);
            r_err   <= i_flag || too_long;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
        end else if (i_start) begin
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_idx   <= r_idx + 1'b1;
            r_done  <= (r_idx == last_idx);
            r_valid <= 1'b1;
        end else if (i_tready) begin
            r_valid <= 1'b0;
        end
    end

    assign o_tvalid  = r_valid;
    assign o_word    = r_word;
    assign o_index   = r_index;
    assign o_last    = r_last;
    assign o_err     = r_err;
    assign o_drained = r_valid && r_last && i_tready;

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_tready && !r_last) |=> (r_valid && r_index == $past(r_index) + 5'd1))
        else $error("record word skipped or repeated");

    a_last_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_last) |-> (r_index == last_idx))
        else $error("terminator word not at the end of the record");

endmodule

// File: tb/unwind_frame_record_encoder_tb.sv
// Self-checking testbench for the unwind frame record encoder.
`timescale 1ns / 100ps

module unwind_frame_record_encoder_tb;
    import ufre_pkg::*;

    localparam logic [1:0] CFG_SPARE_A = 2'd2;
    localparam logic [1:0] CFG_SPARE_B = 2'd3;

    typedef struct {
        logic [63:0] waddr;
        logic [63:0] caddr;
        logic [31:0] csize;
        logic [15:0] ssize;
        logic [17:0] alloc;
        logic        thunk;
        logic [15:0] lrsave;
    } t_unwind_fn;

    typedef struct {
        logic [31:0] word;
        logic [4:0]  index;
        logic        last;
        logic        error;
    } t_record_word;

    class t_record_board;
        logic [63:0]  write_base;
        logic [63:0]  execute_base;
        t_record_word pending_words[$];
        int           errors;
        logic [7:0]   rec[256];
        int unsigned  pos;
        bit           flag;

        function new();
            write_base = '0;
            execute_base = '0;
            errors = 0;
        endfunction

        function void set_base(logic [1:0] index, logic [63:0] value);
            case (index)
                CFG_WRITE_BASE: begin
                    write_base = value;
                end
                CFG_EXEC_BASE: begin
                    execute_base = value;
                end
                default: begin
                end
            endcase
        endfunction

        function void put8(int unsigned v);
            rec[pos] = v[7:0];
            pos = (pos + 1) & 255;
        endfunction

        function void put32(int unsigned v);
            put8(v);
            put8(v >> 8);
            put8(v >> 16);
            put8(v >> 24);
        endfunction

        function void put_uleb(int unsigned v);
            int unsigned b;
            do begin
                b = v & 32'h7f;
                v = v >> 7;
                if (v != 0) begin
                    b = b | 32'h80;
                end
                put8(b);
            end while (v != 0);
        endfunction

        function int unsigned save_slot(int unsigned cfa, int unsigned k);
            if (k > cfa) begin
                flag = 1'b1;
                return 0;
            end
            return (cfa - k) / 8;
        endfunction

        function void add_function(t_unwind_fn r);
            logic [63:0]  exec_rec;
            logic [63:0]  pcrel;
            int unsigned  fde_start;
            int unsigned  body_len;
            int unsigned  nwords;
            int unsigned  f;
            int unsigned  b;
            t_record_word w;
            foreach (rec[k]) rec[k] = 8'h00;
            pos = 0;
            flag = 1'b0;

            put32(16);
            put32(0);
            put8(1);
            put8(8'h7a);
            put8(8'h52);
            put8(0);
            put_uleb(4);
            put8(8'h78);
            put_uleb(30);
            put_uleb(1);
            put8(8'h1b);
            put8(8'h0c);
            put_uleb(31);
            put_uleb(0);

            put32(0);
            fde_start = pos;
            put32(fde_start);
            exec_rec = r.waddr - write_base + execute_base;
            pcrel = r.caddr - (exec_rec + 64'(pos));
            put32(pcrel[31:0]);
            put32(r.csize);
            put_uleb(0);

            if (r.ssize != 0) begin
                if (r.alloc != 0) begin
                    f = r.alloc / 4;
                    if (f < 64) begin
                        put8(ADV_SHORT | f);
                    end else if (f < 256) begin
                        put8(ADV_LOC1);
                        put8(f);
                    end else begin
                        put8(ADV_LOC2);
                        put8(f);
                        put8(f >> 8);
                    end
                end
                put8(DEF_CFA_OF);
                put_uleb(r.ssize);
                if (r.thunk) begin
                    for (int i = 0; i < 12; i++) begin
                        put8(OFS_GPR + i);
                        put_uleb(save_slot(r.ssize, i * 8));
                    end
                    for (int i = 0; i < 8; i++) begin
                        put8(OFS_EXT);
                        put_uleb(VREG_BASE + i);
                        put_uleb(save_slot(r.ssize, VEC_K0 + i * 16));
                    end
                end else if (r.lrsave != 0) begin
                    put8(OFS_LR);
                    put_uleb(save_slot(r.ssize, r.lrsave));
                end
            end

            while (((pos - fde_start) & 7) != 0) begin
                put8(0);
            end
            body_len = pos - fde_start;
            rec[fde_start - 4] = body_len[7:0];
            rec[fde_start - 3] = body_len[15:8];
            put32(0);
            if (pos > UFRE_MAX_RECORD_BYTES) begin
                flag = 1'b1;
            end

            nwords = pos / 4;
            if (nwords > 32) begin
                nwords = 32;
            end
            for (int unsigned i = 0; i < nwords; i++) begin
                b = i * 4;
                w.word = {rec[b + 3], rec[b + 2], rec[b + 1], rec[b]};
                w.index = i[4:0];
                w.last = (i + 1 == nwords);
                w.error = flag;
                pending_words = {pending_words, w};
            end
        endfunction

        function void check_word(logic [31:0] word, logic [4:0] index, logic last,
                                 logic error);
            t_record_word e;
            if (pending_words.size() == 0) begin
                $display("%0t: unexpected word %h index %0d", $time, word, index);
                errors++;
                return;
            end
            e = pending_words.pop_front();
            if (word !== e.word) begin
                $display("%0t: word %0d expected %h actual %h", $time, e.index, e.word, word);
                errors++;
            end
            if (index !== e.index) begin
                $display("%0t: index expected %0d actual %0d", $time, e.index, index);
                errors++;
            end
            if (last !== e.last) begin
                $display("%0t: word %0d last expected %b actual %b", $time, e.index, e.last,
                         last);
                errors++;
            end
            if (error !== e.error) begin
                $display("%0t: word %0d layout error expected %b actual %b", $time, e.index,
                         e.error, error);
                errors++;
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [215:0] i_s_axis_tdata;
    logic         i_s_axis_tuser;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [39:0]  o_m_axis_tdata;
    logic         o_m_axis_tlast;
    logic         o_m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [63:0]  i_cfg_data;

    t_record_board board;
    bit            calm;
    int            stall_left;

    unwind_frame_record_encoder dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 15);
        if (calm || r < 9) begin
            return 0;
        end
        if (r < 14) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic t_unwind_fn make_fn(logic [63:0] waddr, logic [63:0] caddr,
                                           logic [31:0] csize, logic [15:0] ssize,
                                           logic [17:0] alloc, logic thunk,
                                           logic [15:0] lrsave);
        t_unwind_fn fn;
        fn.waddr = waddr;
        fn.caddr = caddr;
        fn.csize = csize;
        fn.ssize = ssize;
        fn.alloc = alloc;
        fn.thunk = thunk;
        fn.lrsave = lrsave;
        return fn;
    endfunction

    function automatic t_unwind_fn rand_fn();
        t_unwind_fn fn;
        fn.waddr = {$urandom, $urandom};
        fn.caddr = ($urandom_range(0, 1) == 0) ? fn.waddr + $urandom_range(0, 4096)
                                               : {$urandom, $urandom};
        fn.csize = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 4096) : $urandom;
        if ($urandom_range(0, 9) < 8) begin
            fn.ssize = 16'(($urandom_range(0, 3) == 0) ? $urandom_range(1, 65535)
                                                       : $urandom_range(1, 300));
            case ($urandom_range(0, 4))
                0: fn.alloc = '0;
                1: fn.alloc = 18'($urandom_range(4, 255));
                2: fn.alloc = 18'($urandom_range(256, 1023));
                3: fn.alloc = 18'($urandom_range(1024, 262143));
                default: fn.alloc = 18'($urandom_range(1, 3));
            endcase
            fn.thunk = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: fn.lrsave = '0;
                3: fn.lrsave = 16'($urandom_range(0, 65535));
                default: fn.lrsave = 16'($urandom_range(1, fn.ssize));
            endcase
        end else begin
            fn.ssize = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom);
            fn.alloc = 18'($urandom);
            fn.thunk = 1'($urandom_range(0, 1));
            fn.lrsave = 16'($urandom);
        end
        return fn;
    endfunction

    task automatic send_fn(t_unwind_fn fn);
        int gap;
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata = {6'b0, fn.lrsave, fn.alloc, fn.ssize, fn.csize, fn.caddr, fn.waddr};
        i_s_axis_tuser = fn.thunk;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.add_function(fn);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic wait_all_words(int settle);
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (board.pending_words.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] index, logic [63:0] value);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.set_base(index, value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        stall_left = 0;
        i_m_axis_tready = 1'b1;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_m_axis_tready = 1'b0;
            end else begin
                stall_left = pick_gap();
                i_m_axis_tready = (stall_left == 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
                board.check_word(o_m_axis_tdata[31:0], o_m_axis_tdata[36:32], o_m_axis_tlast,
                                 o_m_axis_tuser);
            end
        end
    end

    initial begin
        #25ms;
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [63:0] ones;
        ones = '1;
        board = new();
        calm = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_s_axis_tuser = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_WRITE_BASE;
        i_cfg_data = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        send_fn(make_fn('0, '0, '0, '0, '0, 1'b0, '0));
        send_fn(make_fn(ones, ones, '1, '1, '1, 1'b1, '1));
        send_fn(make_fn(ones, '0, '1, '1, '1, 1'b0, '1));
        send_fn(make_fn({32{2'b10}}, {32{2'b01}}, 32'h5555_aaaa, 16'd1, 18'd1, 1'b0,
                        16'd8));
        send_fn(make_fn({32{2'b01}}, {32{2'b10}}, 32'haaaa_5555, 16'd48, 18'd3, 1'b0,
                        16'd0));
        send_fn(make_fn(64'h1000, 64'h2000, 32'd64, 16'd64, 18'd252, 1'b0, 16'd16));
        send_fn(make_fn(64'h1000, 64'h0800, 32'd96, 16'd80, 18'd256, 1'b0, 16'd80));
        send_fn(make_fn(64'h2000, 64'h3000, 32'd200, 16'd80, 18'd1023, 1'b0, 16'd81));
        send_fn(make_fn(64'h3000, 64'h3000, 32'd300, 16'd96, 18'd1024, 1'b0, 16'd8));
        send_fn(make_fn(64'h4000, 64'h5000, 32'd1, 16'd256, 18'd16, 1'b1, 16'd0));
        send_fn(make_fn(64'h4000, 64'h5000, 32'd2, 16'd208, 18'd0, 1'b1, 16'd0));
        send_fn(make_fn(64'h4000, 64'h5000, 32'd3, 16'd100, 18'd512, 1'b1, 16'd0));
        send_fn(make_fn(64'h4000, 64'h5000, 32'd4, 16'd8, 18'd262143, 1'b1, 16'd0));
        send_fn(make_fn(64'h5000, 64'h6000, 32'd5, 16'd0, 18'd400, 1'b1, 16'd32));
        send_fn(make_fn(64'h5000, 64'h6000, 32'd6, 16'd127, 18'd0, 1'b0, 16'd127));
        send_fn(make_fn(64'h5000, 64'h6000, 32'd7, 16'd128, 18'd0, 1'b0, 16'd0));
        send_fn(make_fn(64'h5000, 64'h6000, 32'd8, 16'd16384, 18'd0, 1'b1, 16'd0));
        send_fn(make_fn(64'h6000, 64'h7000, 32'd9, 16'd65535, 18'd4, 1'b0, 16'd65535));

        for (int phase = 0; phase < 6; phase++) begin
            wait_all_words(8);
            case (phase)
                0: begin
                    calm = 1'b1;
                    write_reg(CFG_WRITE_BASE, ones);
                    write_reg(CFG_EXEC_BASE, ones);
                end
                1: begin
                    calm = 1'b0;
                    write_reg(CFG_WRITE_BASE, {$urandom, $urandom});
                    write_reg(CFG_EXEC_BASE, {$urandom, $urandom});
                    write_reg(CFG_SPARE_A, {$urandom, $urandom});
                end
                2: begin
                    write_reg(CFG_WRITE_BASE, {$urandom, $urandom});
                    write_reg(CFG_EXEC_BASE, '0);
                end
                3: begin
                    write_reg(CFG_WRITE_BASE, '0);
                    write_reg(CFG_EXEC_BASE, ones);
                    write_reg(CFG_SPARE_B, ones);
                end
                4: begin
                    write_reg(CFG_EXEC_BASE, {$urandom, $urandom});
                end
                default: begin
                    write_reg(CFG_WRITE_BASE, '0);
                    write_reg(CFG_EXEC_BASE, '0);
                end
            endcase
            for (int n = 0; n < 60; n++) begin
                if ($urandom_range(0, 49) == 0) begin
                    wait_all_words(0);
                end
                send_fn(rand_fn());
            end
        end

        wait_all_words(100);
        if (board.errors == 0 && board.pending_words.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
